// ----- hw/rtl/beacon_parse_ap_table_core_defines.svh -----
// assertion macros used by the beacon parser table engine
`ifndef BEACON_PARSE_AP_TABLE_CORE_DEFINES_SVH
`define BEACON_PARSE_AP_TABLE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BPAT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BPAT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bpat_pkg.sv -----
// types and constants of the beacon parser and access point table
`timescale 1ns / 1ps
package bpat_pkg;

    localparam int TABLE_DEPTH_DEF = 20;
    localparam int NAME_MAX        = 32;

    localparam logic [2:0] ST_NOT_BEACON = 3'd0;
    localparam logic [2:0] ST_SHORT      = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_NEW        = 3'd3;
    localparam logic [2:0] ST_UPDATED    = 3'd4;

    localparam logic [2:0] ENC_OPEN = 3'd0;
    localparam logic [2:0] ENC_WEP  = 3'd1;
    localparam logic [2:0] ENC_WPA  = 3'd2;
    localparam logic [2:0] ENC_WPA2 = 3'd3;
    localparam logic [2:0] ENC_WPA3 = 3'd4;

    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef struct packed {
        logic              opcode;
        logic [7:0]        frame_byte;
        logic              first_byte;
        logic              last_byte;
        logic              is_mgmt;
        logic [11:0]       frame_length;
        logic [3:0]        rx_channel;
        logic signed [7:0] rx_rssi;
    } in_item_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [5:0]        entry_index;
        logic [6:0]        entry_count;
        logic [47:0]       ap_mac;
        logic [3:0]        ap_channel;
        logic signed [7:0] ap_rssi;
        logic [2:0]        enc_class;
        logic [7:0]        name_byte;
        logic              name_byte_valid;
        logic              last_of_run;
    } out_item_t;

    typedef enum logic [1:0] {
        FK_REJECT = 2'd0,
        FK_SHORT  = 2'd1,
        FK_OK     = 2'd2
    } fin_kind_t;

    // frame summary handed from the parser to the table engine
    typedef struct packed {
        fin_kind_t         kind;
        logic [47:0]       mac;
        logic [2:0]        enc;
        logic [5:0]        name_len;
        logic [3:0]        channel;
        logic signed [7:0] rssi;
    } fin_t;

endpackage

// ----- hw/rtl/beacon_parse_ap_table_core.sv -----
// Beacon parser with access point table, top level.
// Input channel s_*: one item per frame byte (opcode byte) or a table clear
// (opcode clear). Bytes of a frame are taken at one per cycle; first_byte
// starts a frame and last_byte ends it.
// Result channel m_*: a frame's last byte causes one result, or for a new
// table entry one result per ssid byte with last_of_run on the final one.
// Sequence: the last byte registers a frame summary for the engine, which reads
// and then compares each table entry searched on the shared comparator, decides
// when no entry matches, then gives one result per cycle while m_ready.
// Throughput: one byte per cycle inside a frame; s_ready is low from the last
// byte until the final result is placed in the output register.
// A stalled receiver holds the output register; the sequencer waits and the
// input stays not ready until the run is fully loaded.
// Reset (aresetn low, synchronous) empties the table, idles the parser and
// drops any pending result. The table memory needs no clearing pass.
`timescale 1ns / 1ps
module beacon_parse_ap_table_core #(
    parameter int TABLE_DEPTH = bpat_pkg::TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bpat_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bpat_pkg::out_item_t m_data
);
    import bpat_pkg::*;

    logic       eng_idle;
    logic       fin_valid;
    fin_t       fin;
    logic [4:0] name_addr;
    logic [7:0] name_data;
    logic       acc;
    logic       byte_acc;
    logic       clear_acc;

    // input handshake and opcode split
    assign s_ready   = eng_idle && !fin_valid;
    assign acc       = s_valid && s_ready;
    assign byte_acc  = acc && (s_data.opcode == OP_BYTE);
    assign clear_acc = acc && (s_data.opcode == OP_CLEAR);

    bpat_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_acc  (byte_acc),
        .item      (s_data),
        .name_addr (name_addr),
        .name_data (name_data),
        .fin_valid (fin_valid),
        .fin       (fin)
    );

    bpat_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .clear     (clear_acc),
        .fin_valid (fin_valid),
        .fin       (fin),
        .name_addr (name_addr),
        .name_data (name_data),
        .idle      (eng_idle),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ----- hw/rtl/bpat_parser.sv -----
// byte-serial beacon parser: header fields, tagged elements, frame summary
`timescale 1ns / 1ps
module bpat_parser (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             byte_acc,
    input  bpat_pkg::in_item_t item,
    input  logic [4:0]       name_addr,
    output logic [7:0]       name_data,
    output logic             fin_valid,
    output bpat_pkg::fin_t   fin
);
    import bpat_pkg::*;

    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_FIXED   = 7'b0000010,
        PH_TAG_ID  = 7'b0000100,
        PH_TAG_LEN = 7'b0001000,
        PH_TAG_VAL = 7'b0010000,
        PH_DONE    = 7'b0100000,
        PH_REJECT  = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic priv;
        logic ssid;
        logic rsn;
        logic sae;
        logic wpa;
    } flags_t;

    phase_t      phase_reg, phase_next;
    logic [11:0] pos_reg, pos_next;
    logic [47:0] mac_reg, mac_next;
    flags_t      flags_reg, flags_next;
    logic [5:0]  nlen_reg, nlen_next;
    logic [7:0]  tid_reg, tid_next;
    logic [7:0]  tlen_reg, tlen_next;
    logic [7:0]  tpos_reg, tpos_next;
    logic [15:0] pair_reg, pair_next;
    logic [15:0] akm_reg, akm_next;
    logic [31:0] suite_reg, suite_next;
    logic [7:0]  frame_name_reg [NAME_MAX];
    logic [7:0]  name_data_reg;
    logic        fin_valid_reg, fin_valid_next;
    fin_t        fin_reg, fin_next;
    logic        name_we;
    logic [4:0]  name_wa;

    assign name_data = name_data_reg;
    assign fin_valid = fin_valid_reg;
    assign fin       = fin_reg;

    // one frame byte per step
    always_comb begin
        logic              open;
        logic [7:0]        b;
        logic signed [13:0] total;
        logic signed [13:0] spos;
        logic [18:0]       akm_at;
        logic [18:0]       i19;
        logic [18:0]       rel;
        logic [2:0]        enc;
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        mac_next       = mac_reg;
        flags_next     = flags_reg;
        nlen_next      = nlen_reg;
        tid_next       = tid_reg;
        tlen_next      = tlen_reg;
        tpos_next      = tpos_reg;
        pair_next      = pair_reg;
        akm_next       = akm_reg;
        suite_next     = suite_reg;
        fin_valid_next = 1'b0;
        fin_next       = fin_reg;
        name_we        = 1'b0;
        name_wa        = tpos_reg[4:0];
        b              = item.frame_byte;
        total          = $signed({2'b00, item.frame_length}) - 14'sd40;
        open           = item.first_byte || (phase_reg != PH_IDLE);
        akm_at         = '0;
        i19            = '0;
        rel            = '0;
        enc            = ENC_OPEN;
        spos           = '0;
        if (byte_acc && open) begin
            // a first byte always restarts the parse
            if (item.first_byte) begin
                pos_next   = '0;
                mac_next   = '0;
                flags_next = '0;
                nlen_next  = '0;
                tid_next   = '0;
                tlen_next  = '0;
                tpos_next  = '0;
                pair_next  = '0;
                akm_next   = '0;
                suite_next = '0;
                phase_next = item.is_mgmt ? PH_FIXED : PH_REJECT;
            end
            spos = $signed({2'b00, pos_next});
            if (pos_next != 12'hFFF) begin
                case (phase_next)
                    PH_FIXED: begin
                        if (pos_next == 12'd0 && (b & 8'hFC) != 8'h80) begin
                            phase_next = PH_REJECT;
                        end else begin
                            if (pos_next >= 12'd16 && pos_next <= 12'd21) begin
                                mac_next = {mac_next[39:0], b};
                            end
                            if (pos_next == 12'd34 && (b & 8'h10) != 8'h00) begin
                                flags_next.priv = 1'b1;
                            end
                            if (pos_next == 12'd35) begin
                                phase_next = PH_TAG_ID;
                            end
                        end
                    end
                    PH_TAG_ID: begin
                        if (spos - 14'sd34 > total) begin
                            phase_next = PH_DONE;
                        end else begin
                            tid_next   = b;
                            phase_next = PH_TAG_LEN;
                        end
                    end
                    PH_TAG_LEN: begin
                        if (spos + $signed({6'd0, b}) - 14'sd35 > total) begin
                            phase_next = PH_DONE;
                        end else begin
                            tlen_next = b;
                            tpos_next = '0;
                            if (tid_next == 8'd0 && b <= 8'(NAME_MAX)) begin
                                flags_next.ssid = 1'b1;
                                nlen_next       = b[5:0];
                            end else if (tid_next == 8'd48 && b >= 8'd2) begin
                                flags_next.rsn = 1'b1;
                                pair_next      = '0;
                                akm_next       = '0;
                            end
                            phase_next = (b != 8'd0) ? PH_TAG_VAL : PH_TAG_ID;
                        end
                    end
                    PH_TAG_VAL: begin
                        suite_next = {suite_next[23:0], b};
                        i19        = {11'd0, tpos_next};
                        akm_at     = 19'd8 + {1'b0, pair_next, 2'b00};
                        if (tid_next == 8'd0 && tlen_next <= 8'(NAME_MAX)) begin
                            // ssid body, length already bounded by the name size
                            name_we = 1'b1;
                            name_wa = tpos_next[4:0];
                        end else if (tid_next == 8'd48 && tlen_next >= 8'd2) begin
                            if (tlen_next >= 8'd8) begin
                                if (tpos_next == 8'd6) begin
                                    pair_next = {8'd0, b};
                                end else if (tpos_next == 8'd7) begin
                                    pair_next = pair_next | {b, 8'd0};
                                end else if (tpos_next >= 8'd8) begin
                                    if (i19 == akm_at) begin
                                        akm_next = {8'd0, b};
                                    end else if (i19 == akm_at + 19'd1) begin
                                        akm_next = akm_next | {b, 8'd0};
                                    end else if (i19 >= akm_at + 19'd2) begin
                                        rel = i19 - akm_at - 19'd2;
                                        if (rel[1:0] == 2'd3 &&
                                            {10'd0, rel[7:2]} < akm_next &&
                                            suite_next == 32'h000FAC08) begin
                                            flags_next.sae = 1'b1;
                                        end
                                    end
                                end
                            end
                        end else if (tid_next == 8'd221 && tlen_next >= 8'd4) begin
                            if (tpos_next == 8'd3 && suite_next == 32'h0050F201) begin
                                flags_next.wpa = 1'b1;
                            end
                        end
                        tpos_next = tpos_next + 8'd1;
                        if (tpos_next >= tlen_next) begin
                            phase_next = PH_TAG_ID;
                        end
                    end
                    default: begin
                    end
                endcase
                pos_next = pos_next + 12'd1;
            end
            // frame end: summarize for the table engine
            if (item.last_byte) begin
                if (!flags_next.priv)    enc = ENC_OPEN;
                else if (flags_next.sae) enc = ENC_WPA3;
                else if (flags_next.rsn) enc = ENC_WPA2;
                else if (flags_next.wpa) enc = ENC_WPA;
                else                     enc = ENC_WEP;
                fin_valid_next   = 1'b1;
                fin_next.mac     = mac_next;
                fin_next.enc     = enc;
                fin_next.name_len = nlen_next;
                fin_next.channel = item.rx_channel;
                fin_next.rssi    = item.rx_rssi;
                if (phase_next == PH_REJECT) begin
                    fin_next.kind = FK_REJECT;
                end else if (total < 14'sd2 ||
                             $signed({2'b00, pos_next}) < total + 14'sd36 ||
                             !flags_next.ssid || nlen_next == 6'd0) begin
                    fin_next.kind = FK_SHORT;
                end else begin
                    fin_next.kind = FK_OK;
                end
                phase_next = PH_IDLE;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            mac_reg       <= '0;
            flags_reg     <= '0;
            nlen_reg      <= '0;
            tid_reg       <= '0;
            tlen_reg      <= '0;
            tpos_reg      <= '0;
            pair_reg      <= '0;
            akm_reg       <= '0;
            suite_reg     <= '0;
            fin_valid_reg <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            mac_reg       <= mac_next;
            flags_reg     <= flags_next;
            nlen_reg      <= nlen_next;
            tid_reg       <= tid_next;
            tlen_reg      <= tlen_next;
            tpos_reg      <= tpos_next;
            pair_reg      <= pair_next;
            akm_reg       <= akm_next;
            suite_reg     <= suite_next;
            fin_valid_reg <= fin_valid_next;
        end
    end

    // ssid bytes with a registered read port, and frame summary
    always_ff @(posedge aclk) begin
        fin_reg <= fin_next;
        if (name_we) begin
            frame_name_reg[name_wa] <= item.frame_byte;
        end
        name_data_reg <= frame_name_reg[name_addr];
    end

endmodule

// ----- hw/rtl/bpat_engine.sv -----
// table engine: serial bssid search over the mac memory, append and result emission
`timescale 1ns / 1ps
`include "beacon_parse_ap_table_core_defines.svh"
module bpat_engine #(
    parameter int TABLE_DEPTH = bpat_pkg::TABLE_DEPTH_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                clear,
    input  logic                fin_valid,
    input  bpat_pkg::fin_t      fin,
    output logic [4:0]          name_addr,
    input  logic [7:0]          name_data,
    output logic                idle,
    output logic                m_valid,
    input  logic                m_ready,
    output bpat_pkg::out_item_t m_data
);
    import bpat_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    typedef enum logic [4:0] {
        E_IDLE   = 5'b00001,
        E_READ   = 5'b00010,
        E_CMP    = 5'b00100,
        E_DECIDE = 5'b01000,
        E_EMIT   = 5'b10000
    } eng_state_t;

    eng_state_t  state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] scan_reg, scan_next;
    fin_t        hold_reg, hold_next;
    out_item_t   res_reg, res_next;
    logic [5:0]  k_reg, k_next;
    logic [5:0]  len_reg, len_next;
    logic        named_reg, named_next;
    logic        m_valid_reg, m_valid_next;
    out_item_t   m_data_reg, m_data_next;
    logic [47:0] mac_mem [TABLE_DEPTH];
    logic [47:0] rd_data_reg;
    logic        mem_we;
    logic        fill_hold;

    assign idle      = (state_reg == E_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    // name memory read is registered, so it is addressed with k_next, in the cycle before its byte is used
    assign name_addr = k_next[4:0];
    assign fill_hold = !clear && state_reg != E_DECIDE;

    // sequencer
    always_comb begin
        logic load;
        state_next   = state_reg;
        fill_next    = fill_reg;
        scan_next    = scan_reg;
        hold_next    = hold_reg;
        res_next     = res_reg;
        k_next       = k_reg;
        len_next     = len_reg;
        named_next   = named_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mem_we       = 1'b0;
        load         = 1'b0;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (clear) begin
            fill_next = '0;
        end
        case (state_reg)
            E_IDLE: begin
                if (fin_valid) begin
                    hold_next = fin;
                    scan_next = '0;
                    k_next    = '0;
                    len_next  = 6'd1;
                    named_next = 1'b0;
                    res_next  = '0;
                    res_next.entry_count = 7'(fill_reg);
                    if (fin.kind == FK_REJECT) begin
                        res_next.status = ST_NOT_BEACON;
                        state_next      = E_EMIT;
                    end else if (fin.kind == FK_SHORT) begin
                        res_next.status = ST_SHORT;
                        state_next      = E_EMIT;
                    end else begin
                        state_next = (fill_reg == '0) ? E_DECIDE : E_READ;
                    end
                end
            end
            E_READ: begin
                state_next = E_CMP;
            end
            E_CMP: begin
                if (rd_data_reg == hold_reg.mac) begin
                    res_next.status      = ST_UPDATED;
                    res_next.entry_index = 6'(scan_reg);
                    res_next.ap_mac      = hold_reg.mac;
                    res_next.ap_channel  = hold_reg.channel;
                    res_next.ap_rssi     = hold_reg.rssi;
                    res_next.enc_class   = hold_reg.enc;
                    state_next           = E_EMIT;
                end else if (scan_reg + CNT_W'(1) < fill_reg) begin
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = E_READ;
                end else begin
                    state_next = E_DECIDE;
                end
            end
            E_DECIDE: begin
                res_next.ap_mac    = hold_reg.mac;
                res_next.enc_class = hold_reg.enc;
                if (fill_reg >= CNT_W'(TABLE_DEPTH)) begin
                    res_next.status = ST_FULL;
                end else begin
                    mem_we               = 1'b1;
                    fill_next            = fill_reg + CNT_W'(1);
                    res_next.status      = ST_NEW;
                    res_next.entry_index = 6'(fill_reg);
                    res_next.entry_count = 7'(fill_reg) + 7'd1;
                    res_next.ap_channel  = hold_reg.channel;
                    res_next.ap_rssi     = hold_reg.rssi;
                    len_next             = hold_reg.name_len;
                    named_next           = 1'b1;
                end
                state_next = E_EMIT;
            end
            E_EMIT: begin
                // one result per free output slot
                if (!m_valid_reg || m_ready) begin
                    load = 1'b1;
                end
            end
            default: begin
                state_next = E_IDLE;
            end
        endcase
        if (load) begin
            m_valid_next                = 1'b1;
            m_data_next                 = res_reg;
            m_data_next.name_byte       = named_reg ? name_data : 8'd0;
            m_data_next.name_byte_valid = named_reg;
            m_data_next.last_of_run     = (k_reg + 6'd1 == len_reg);
            k_next                      = k_reg + 6'd1;
            if (k_reg + 6'd1 == len_reg) begin
                state_next = E_IDLE;
            end
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= E_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload state
    always_ff @(posedge aclk) begin
        scan_reg   <= scan_next;
        hold_reg   <= hold_next;
        res_reg    <= res_next;
        k_reg      <= k_next;
        len_reg    <= len_next;
        named_reg  <= named_next;
        m_data_reg <= m_data_next;
    end

    // bssid memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mac_mem[fill_reg[IDX_W-1:0]] <= hold_reg.mac;
        end
        rd_data_reg <= mac_mem[scan_reg[IDX_W-1:0]];
    end

    `BPAT_ASSERT_IMPL(a_fill_bound, 1'b1, fill_reg <= CNT_W'(TABLE_DEPTH), "table fill past depth")
    `BPAT_ASSERT_IMPL(a_fin_when_idle, fin_valid, state_reg == E_IDLE, "frame summary while busy")
    `BPAT_ASSERT_NEXT(a_fill_step, fill_hold, fill_reg == $past(fill_reg), "fill moved")
    `BPAT_ASSERT_IMPL(a_scan_in_range, state_reg == E_CMP, scan_reg < fill_reg, "scan past fill")

endmodule
